FILE: design/buddy_page_allocator_assert.svh
// Assertion macros used by the buddy page allocator checker.
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("buddy page allocator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("buddy page allocator check failed");

`endif

FILE: design/bpa_pkg.sv
// Shared types and constants of the buddy page allocator.
package bpa_pkg;

    localparam int ADDR_W     = 48;
    localparam int PAGE_SHIFT = 12;
    localparam int PFN_W      = 36;
    localparam int CNT_W      = 13;
    localparam int OP_W       = 2;
    localparam int ST_W       = 2;
    localparam int CFG_IDX_W  = 1;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_INIT  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_BLOCK = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE    = 2'd2;
    localparam logic [ST_W-1:0] ST_NOT_LIVE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_PAGE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT = 1'd1;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_CLEAR_STEP,
        CMD_FAIL,
        CMD_SEARCH,
        CMD_UNL_READ,
        CMD_UNL_LINK,
        CMD_UNL_BACK,
        CMD_SPLIT,
        CMD_PREP_PUSH,
        CMD_PUSH_HEAD,
        CMD_PUSH_BACK,
        CMD_ALLOC_FIN,
        CMD_FREE_READ,
        CMD_FREE_TAKE,
        CMD_REL_BUD,
        CMD_REL_READ,
        CMD_MERGE,
        CMD_INIT_START,
        CMD_INIT_BLOCK,
        CMD_RESULT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t         op;
        logic [ST_W-1:0] code;
    } bpa_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            too_big;
        logic            found;
        logic            range_bad;
        logic            not_live;
        logic            ord_at_max;
        logic            bud_match;
        logic            split_more;
        logic            init_more;
        logic            clear_last;
        logic            out_free;
    } bpa_stat_t;

endpackage

FILE: design/bpa_if.sv
// Request and response channel interfaces of the buddy page allocator.
interface bpa_req_if;
    logic                          valid;
    logic                          ready;
    logic [bpa_pkg::OP_W-1:0]      op;
    logic [bpa_pkg::ADDR_W-1:0]    size_bytes;
    logic [bpa_pkg::ADDR_W-1:0]    address;

    modport source (output valid, output op, output size_bytes, output address, input ready);
    modport sink (input valid, input op, input size_bytes, input address, output ready);
endinterface

interface bpa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bpa_pkg::ST_W-1:0]      status;
    logic [bpa_pkg::ADDR_W-1:0]    block_address;
    logic [bpa_pkg::CNT_W-1:0]     allocated_pages;
    logic [bpa_pkg::CNT_W-1:0]     free_pages;

    modport source (output valid, output status, output block_address,
                    output allocated_pages, output free_pages, input ready);
    modport sink (input valid, input status, input block_address,
                  input allocated_pages, input free_pages, output ready);
endinterface

FILE: design/bpa_ctrl.sv
// Sequencing state machine of the buddy page allocator.
module bpa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  bpa_pkg::bpa_stat_t stat,
    output bpa_pkg::bpa_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_UNL_READ,
        S_UNL_LINK,
        S_UNL_BACK,
        S_MERGE,
        S_SPLIT,
        S_PUSH_HEAD,
        S_PUSH_BACK,
        S_FREE_CHECK,
        S_REL_BUD,
        S_REL_READ,
        S_REL_CHECK,
        S_INIT_CLEAR,
        S_INIT_NEXT,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = bpa_pkg::CMD_NONE;
        cmd.code   = bpa_pkg::ST_OK;
        req_ready  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = bpa_pkg::CMD_CLEAR_STEP;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op     = bpa_pkg::CMD_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.op)
                    bpa_pkg::OP_ALLOC:
                    begin
                        if (stat.too_big || !stat.found)
                        begin
                            cmd.op     = bpa_pkg::CMD_FAIL;
                            cmd.code   = bpa_pkg::ST_NO_BLOCK;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.op     = bpa_pkg::CMD_SEARCH;
                            state_next = S_UNL_READ;
                        end
                    end
                    bpa_pkg::OP_FREE:
                    begin
                        cmd.op     = bpa_pkg::CMD_FREE_READ;
                        state_next = S_FREE_CHECK;
                    end
                    bpa_pkg::OP_INIT:
                    begin
                        cmd.op     = bpa_pkg::CMD_INIT_START;
                        state_next = S_INIT_CLEAR;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_UNL_READ:
            begin
                cmd.op     = bpa_pkg::CMD_UNL_READ;
                state_next = S_UNL_LINK;
            end
            S_UNL_LINK:
            begin
                cmd.op     = bpa_pkg::CMD_UNL_LINK;
                state_next = S_UNL_BACK;
            end
            S_UNL_BACK:
            begin
                cmd.op = bpa_pkg::CMD_UNL_BACK;
                if (stat.op == bpa_pkg::OP_ALLOC)
                begin
                    state_next = S_SPLIT;
                end
                else
                begin
                    state_next = S_MERGE;
                end
            end
            S_MERGE:
            begin
                cmd.op     = bpa_pkg::CMD_MERGE;
                state_next = S_REL_BUD;
            end
            S_SPLIT:
            begin
                if (stat.split_more)
                begin
                    cmd.op     = bpa_pkg::CMD_SPLIT;
                    state_next = S_PUSH_HEAD;
                end
                else
                begin
                    cmd.op     = bpa_pkg::CMD_ALLOC_FIN;
                    state_next = S_DONE;
                end
            end
            S_PUSH_HEAD:
            begin
                cmd.op     = bpa_pkg::CMD_PUSH_HEAD;
                state_next = S_PUSH_BACK;
            end
            S_PUSH_BACK:
            begin
                cmd.op = bpa_pkg::CMD_PUSH_BACK;
                case (stat.op)
                    bpa_pkg::OP_ALLOC: state_next = S_SPLIT;
                    bpa_pkg::OP_INIT:  state_next = S_INIT_NEXT;
                    default:           state_next = S_DONE;
                endcase
            end
            S_FREE_CHECK:
            begin
                state_next = S_DONE;
                if (stat.range_bad)
                begin
                    cmd.op   = bpa_pkg::CMD_FAIL;
                    cmd.code = bpa_pkg::ST_RANGE;
                end
                else if (stat.not_live)
                begin
                    cmd.op   = bpa_pkg::CMD_FAIL;
                    cmd.code = bpa_pkg::ST_NOT_LIVE;
                end
                else
                begin
                    cmd.op     = bpa_pkg::CMD_FREE_TAKE;
                    state_next = S_REL_BUD;
                end
            end
            S_REL_BUD:
            begin
                if (stat.ord_at_max)
                begin
                    cmd.op     = bpa_pkg::CMD_PREP_PUSH;
                    state_next = S_PUSH_HEAD;
                end
                else
                begin
                    cmd.op     = bpa_pkg::CMD_REL_BUD;
                    state_next = S_REL_READ;
                end
            end
            S_REL_READ:
            begin
                cmd.op     = bpa_pkg::CMD_REL_READ;
                state_next = S_REL_CHECK;
            end
            S_REL_CHECK:
            begin
                if (stat.bud_match)
                begin
                    cmd.op     = bpa_pkg::CMD_UNL_LINK;
                    state_next = S_UNL_BACK;
                end
                else
                begin
                    cmd.op     = bpa_pkg::CMD_PREP_PUSH;
                    state_next = S_PUSH_HEAD;
                end
            end
            S_INIT_CLEAR:
            begin
                cmd.op = bpa_pkg::CMD_CLEAR_STEP;
                if (stat.clear_last)
                begin
                    state_next = S_INIT_NEXT;
                end
            end
            S_INIT_NEXT:
            begin
                if (stat.init_more)
                begin
                    cmd.op     = bpa_pkg::CMD_INIT_BLOCK;
                    state_next = S_REL_BUD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = bpa_pkg::CMD_RESULT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/bpa_datapath.sv
// Free-list memories, registers and arithmetic of the buddy page allocator.
module bpa_datapath #(
    parameter int NUM_PAGES = 4096,
    parameter int MAX_ORDER = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bpa_pkg::PFN_W-1:0]           cfg_data,
    input  logic [bpa_pkg::OP_W-1:0]            in_op,
    input  logic [bpa_pkg::ADDR_W-1:0]          in_size,
    input  logic [bpa_pkg::ADDR_W-1:0]          in_addr,
    input  logic                                rsp_ready,
    input  bpa_pkg::bpa_cmd_t                   cmd,
    output bpa_pkg::bpa_stat_t                  stat,
    output logic                                rsp_valid,
    output logic [bpa_pkg::ST_W-1:0]            rsp_status,
    output logic [bpa_pkg::ADDR_W-1:0]          rsp_block_address,
    output logic [bpa_pkg::CNT_W-1:0]           rsp_allocated,
    output logic [bpa_pkg::CNT_W-1:0]           rsp_free
);

    localparam int AW = $clog2(NUM_PAGES);
    localparam int IW = $clog2(NUM_PAGES + 1);
    localparam int OW = $clog2(MAX_ORDER + 2);
    localparam int SW = (IW > bpa_pkg::CNT_W) ? IW : bpa_pkg::CNT_W;
    localparam int XW = ((SW > MAX_ORDER + 1) ? SW : MAX_ORDER + 1) + 1;
    localparam int AB = bpa_pkg::PFN_W + 1;
    localparam int MW = MAX_ORDER;
    localparam int PS = bpa_pkg::PAGE_SHIFT;

    localparam logic [IW-1:0] NIL      = IW'(NUM_PAGES);
    localparam logic [OW-1:0] NOT_FREE = OW'(MAX_ORDER + 1);
    localparam logic [OW-1:0] ORD_MAX  = OW'(MAX_ORDER);

    logic [OW-1:0] ford_mem [NUM_PAGES];
    logic          live_mem [NUM_PAGES];
    logic [OW-1:0] held_mem [NUM_PAGES];
    logic [IW-1:0] next_mem [NUM_PAGES];
    logic [IW-1:0] prev_mem [NUM_PAGES];

    logic [OW-1:0] ford_q;
    logic          live_q;
    logic [OW-1:0] held_q;
    logic [IW-1:0] next_q;
    logic [IW-1:0] prev_q;

    logic [IW-1:0] head_reg [MAX_ORDER+1];

    logic [bpa_pkg::PFN_W-1:0]  first_reg;
    logic [bpa_pkg::CNT_W-1:0]  pc_reg;
    logic [bpa_pkg::CNT_W-1:0]  total_reg;
    logic [AW-1:0]              clr_reg;
    logic                       rsp_valid_reg;

    logic [bpa_pkg::OP_W-1:0]   op_reg;
    logic                       too_big_reg;
    logic [OW-1:0]              want_reg;
    logic [bpa_pkg::ADDR_W-1:0] addr_reg;
    logic [IW-1:0]              idx_reg;
    logic [OW-1:0]              ord_reg;
    logic [IW-1:0]              tgt_reg;
    logic [OW-1:0]              tord_reg;
    logic                       pv_reg;
    logic [IW-1:0]              h_reg;
    logic [OW-1:0]              uord_reg;
    logic [IW-1:0]              p_reg;
    logic [IW-1:0]              n_reg;
    logic [AB-1:0]              bud_reg;
    logic                       inr_reg;
    logic                       range_bad_reg;
    logic                       unal_reg;
    logic [SW-1:0]              off_reg;
    logic [bpa_pkg::ST_W-1:0]   st_reg;
    logic [bpa_pkg::ADDR_W-1:0] baddr_reg;
    logic [bpa_pkg::ST_W-1:0]   rsp_status_reg;
    logic [bpa_pkg::ADDR_W-1:0] rsp_baddr_reg;
    logic [bpa_pkg::CNT_W-1:0]  rsp_alloc_reg;
    logic [bpa_pkg::CNT_W-1:0]  rsp_free_reg;

    logic [SW-1:0]              span;
    logic [AB-1:0]              pages;
    logic [AB-1:0]              pm1;
    logic                       load_big;
    logic [OW-1:0]              load_want;
    logic                       srch_found;
    logic [OW-1:0]              srch_ord;
    logic [AB-1:0]              first_x;
    logic [AB-1:0]              abs_pg;
    logic [AB-1:0]              fdiff;
    logic                       f_rb;
    logic [AB-1:0]              abs_idx;
    logic [AB-1:0]              bdiff;
    logic                       b_inr;
    logic [OW-1:0]              ord_dec;
    logic [XW-1:0]              up;
    logic [SW-1:0]              rem;
    logic [MW-1:0]              cur_lo;
    logic [OW-1:0]              init_ord;
    logic                       init_stop;
    logic [OW-1:0]              held_ord;
    logic [XW-1:0]              tot_sub;
    logic [XW-1:0]              sz_sub;
    logic [bpa_pkg::CNT_W-1:0]  freep;
    logic                       u_ok;

    logic          ford_we;
    logic [AW-1:0] ford_wa;
    logic [OW-1:0] ford_wd;
    logic          live_we;
    logic [AW-1:0] live_wa;
    logic          live_wd;
    logic          held_we;
    logic          next_we;
    logic [AW-1:0] next_wa;
    logic [IW-1:0] next_wd;
    logic          prev_we;
    logic [AW-1:0] prev_wa;
    logic [IW-1:0] prev_wd;
    logic [AW-1:0] rd_addr;

    assign span = (SW'(pc_reg) > SW'(NUM_PAGES)) ? SW'(NUM_PAGES) : SW'(pc_reg);
    assign first_x = {1'b0, first_reg};

    always_comb
    begin
        pages = {1'b0, in_size[bpa_pkg::ADDR_W-1:PS]} + AB'(|in_size[PS-1:0]);
        pm1 = pages - AB'(1);
        load_big = pages > (AB'(1) << MAX_ORDER);
        load_want = '0;
        for (int b = 0; b < MAX_ORDER; b++)
        begin
            if (pm1[b])
            begin
                load_want = OW'(b + 1);
            end
        end
        if (pages <= AB'(1))
        begin
            load_want = '0;
        end
    end

    always_comb
    begin
        srch_found = 1'b0;
        srch_ord = '0;
        for (int i = MAX_ORDER; i >= 0; i--)
        begin
            if ((OW'(i) >= want_reg) && (head_reg[i] != NIL))
            begin
                srch_found = 1'b1;
                srch_ord = OW'(i);
            end
        end
    end

    always_comb
    begin
        abs_pg = {1'b0, addr_reg[bpa_pkg::ADDR_W-1:PS]};
        fdiff = abs_pg - first_x;
        f_rb = (abs_pg < first_x) || (fdiff >= AB'(span));
        abs_idx = first_x + AB'(idx_reg);
        bdiff = bud_reg - first_x;
        b_inr = (bud_reg >= first_x) && (bdiff < AB'(span));
        ord_dec = ord_reg - OW'(1);
        up = XW'(idx_reg) + (XW'(1) << ord_dec);
        u_ok = ford_q <= ORD_MAX;
        held_ord = (held_q > ORD_MAX) ? ORD_MAX : held_q;
        tot_sub = XW'(total_reg);
        sz_sub = XW'(1) << held_ord;
        freep = (pc_reg >= total_reg) ? (pc_reg - total_reg) : '0;
    end

    always_comb
    begin
        rem = span - off_reg;
        cur_lo = MW'(first_reg) + MW'(off_reg);
        init_ord = '0;
        init_stop = 1'b0;
        for (int k = 1; k <= MAX_ORDER; k++)
        begin
            if (!init_stop && ((cur_lo & MW'((XW'(1) << k) - XW'(1))) == '0)
                && ((XW'(1) << k) <= XW'(rem)))
            begin
                init_ord = OW'(k);
            end
            else
            begin
                init_stop = 1'b1;
            end
        end
    end

    always_comb
    begin
        ford_we = 1'b0;
        ford_wa = tgt_reg[AW-1:0];
        ford_wd = NOT_FREE;
        live_we = 1'b0;
        live_wa = idx_reg[AW-1:0];
        live_wd = 1'b0;
        held_we = 1'b0;
        next_we = 1'b0;
        next_wa = tgt_reg[AW-1:0];
        next_wd = NIL;
        prev_we = 1'b0;
        prev_wa = tgt_reg[AW-1:0];
        prev_wd = NIL;
        rd_addr = tgt_reg[AW-1:0];
        case (cmd.op)
            bpa_pkg::CMD_CLEAR_STEP:
            begin
                ford_we = 1'b1;
                ford_wa = clr_reg;
                live_we = 1'b1;
                live_wa = clr_reg;
            end
            bpa_pkg::CMD_UNL_LINK:
            begin
                ford_we = 1'b1;
                next_we = u_ok && (prev_q != NIL);
                next_wa = prev_q[AW-1:0];
                next_wd = next_q;
            end
            bpa_pkg::CMD_UNL_BACK:
            begin
                prev_we = (uord_reg <= ORD_MAX) && (n_reg != NIL);
                prev_wa = n_reg[AW-1:0];
                prev_wd = p_reg;
            end
            bpa_pkg::CMD_PUSH_HEAD:
            begin
                ford_we = pv_reg;
                ford_wd = tord_reg;
                next_we = pv_reg;
                next_wd = head_reg[tord_reg];
                prev_we = pv_reg;
            end
            bpa_pkg::CMD_PUSH_BACK:
            begin
                prev_we = pv_reg && (h_reg != NIL);
                prev_wa = h_reg[AW-1:0];
                prev_wd = tgt_reg;
            end
            bpa_pkg::CMD_ALLOC_FIN:
            begin
                live_we = 1'b1;
                live_wd = 1'b1;
                held_we = 1'b1;
            end
            bpa_pkg::CMD_FREE_READ:
            begin
                rd_addr = fdiff[AW-1:0];
            end
            bpa_pkg::CMD_FREE_TAKE:
            begin
                live_we = 1'b1;
            end
            bpa_pkg::CMD_REL_READ:
            begin
                rd_addr = bdiff[AW-1:0];
            end
            default:
            begin
                rd_addr = tgt_reg[AW-1:0];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ford_we)
        begin
            ford_mem[ford_wa] <= ford_wd;
        end
        if (live_we)
        begin
            live_mem[live_wa] <= live_wd;
        end
        if (held_we)
        begin
            held_mem[idx_reg[AW-1:0]] <= want_reg;
        end
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
        ford_q <= ford_mem[rd_addr];
        live_q <= live_mem[rd_addr];
        held_q <= held_mem[rd_addr];
        next_q <= next_mem[rd_addr];
        prev_q <= prev_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= MAX_ORDER; i++)
            begin
                head_reg[i] <= NIL;
            end
            first_reg     <= '0;
            pc_reg        <= '0;
            total_reg     <= '0;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == bpa_pkg::REG_FIRST_PAGE))
            begin
                first_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == bpa_pkg::REG_PAGE_COUNT))
            begin
                pc_reg <= cfg_data[bpa_pkg::CNT_W-1:0];
            end
            if (rsp_valid_reg && rsp_ready && (cmd.op != bpa_pkg::CMD_RESULT))
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (cmd.op)
                bpa_pkg::CMD_CLEAR_STEP:
                begin
                    clr_reg <= clr_reg + AW'(1);
                end
                bpa_pkg::CMD_UNL_LINK:
                begin
                    if (u_ok && (prev_q == NIL))
                    begin
                        head_reg[ford_q] <= next_q;
                    end
                end
                bpa_pkg::CMD_PUSH_HEAD:
                begin
                    if (pv_reg)
                    begin
                        head_reg[tord_reg] <= tgt_reg;
                    end
                end
                bpa_pkg::CMD_ALLOC_FIN:
                begin
                    total_reg <= bpa_pkg::CNT_W'(XW'(total_reg) + (XW'(1) << want_reg));
                end
                bpa_pkg::CMD_FREE_TAKE:
                begin
                    total_reg <= (tot_sub >= sz_sub) ?
                                 bpa_pkg::CNT_W'(tot_sub - sz_sub) : '0;
                end
                bpa_pkg::CMD_INIT_START:
                begin
                    for (int i = 0; i <= MAX_ORDER; i++)
                    begin
                        head_reg[i] <= NIL;
                    end
                    total_reg <= '0;
                    clr_reg   <= '0;
                end
                bpa_pkg::CMD_RESULT:
                begin
                    rsp_valid_reg <= 1'b1;
                end
                default:
                begin
                    clr_reg <= clr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            bpa_pkg::CMD_LOAD:
            begin
                op_reg      <= in_op;
                too_big_reg <= load_big;
                want_reg    <= load_want;
                addr_reg    <= in_addr;
                st_reg      <= bpa_pkg::ST_OK;
                baddr_reg   <= '0;
            end
            bpa_pkg::CMD_FAIL:
            begin
                st_reg    <= cmd.code;
                baddr_reg <= '0;
            end
            bpa_pkg::CMD_SEARCH:
            begin
                idx_reg <= head_reg[srch_ord];
                tgt_reg <= head_reg[srch_ord];
                ord_reg <= srch_ord;
            end
            bpa_pkg::CMD_UNL_LINK:
            begin
                uord_reg <= ford_q;
                p_reg    <= prev_q;
                n_reg    <= next_q;
            end
            bpa_pkg::CMD_SPLIT:
            begin
                ord_reg  <= ord_dec;
                tord_reg <= ord_dec;
                tgt_reg  <= up[IW-1:0];
                pv_reg   <= up < XW'(NUM_PAGES);
            end
            bpa_pkg::CMD_PREP_PUSH:
            begin
                tgt_reg  <= idx_reg;
                tord_reg <= ord_reg;
                pv_reg   <= 1'b1;
            end
            bpa_pkg::CMD_PUSH_HEAD:
            begin
                h_reg <= head_reg[tord_reg];
            end
            bpa_pkg::CMD_ALLOC_FIN:
            begin
                baddr_reg <= {abs_idx[bpa_pkg::PFN_W-1:0], {PS{1'b0}}};
            end
            bpa_pkg::CMD_FREE_READ:
            begin
                idx_reg       <= fdiff[IW-1:0];
                range_bad_reg <= f_rb;
                unal_reg      <= |addr_reg[PS-1:0];
            end
            bpa_pkg::CMD_FREE_TAKE:
            begin
                ord_reg <= held_ord;
            end
            bpa_pkg::CMD_REL_BUD:
            begin
                bud_reg <= abs_idx ^ (AB'(1) << ord_reg);
            end
            bpa_pkg::CMD_REL_READ:
            begin
                inr_reg <= b_inr;
                tgt_reg <= bdiff[IW-1:0];
            end
            bpa_pkg::CMD_MERGE:
            begin
                if (tgt_reg < idx_reg)
                begin
                    idx_reg <= tgt_reg;
                end
                ord_reg <= ord_reg + OW'(1);
            end
            bpa_pkg::CMD_INIT_START:
            begin
                off_reg <= '0;
            end
            bpa_pkg::CMD_INIT_BLOCK:
            begin
                idx_reg <= IW'(off_reg);
                ord_reg <= init_ord;
                off_reg <= off_reg + SW'(XW'(1) << init_ord);
            end
            bpa_pkg::CMD_RESULT:
            begin
                rsp_status_reg <= st_reg;
                rsp_baddr_reg  <= baddr_reg;
                rsp_alloc_reg  <= total_reg;
                rsp_free_reg   <= freep;
            end
            default:
            begin
                op_reg <= op_reg;
            end
        endcase
    end

    always_comb
    begin
        stat.op         = op_reg;
        stat.too_big    = too_big_reg;
        stat.found      = srch_found;
        stat.range_bad  = range_bad_reg;
        stat.not_live   = unal_reg || !live_q;
        stat.ord_at_max = ord_reg >= ORD_MAX;
        stat.bud_match  = inr_reg && (ford_q == ord_reg);
        stat.split_more = ord_reg > want_reg;
        stat.init_more  = off_reg < span;
        stat.clear_last = clr_reg == AW'(NUM_PAGES - 1);
        stat.out_free   = !rsp_valid_reg || rsp_ready;
    end

    assign rsp_valid         = rsp_valid_reg;
    assign rsp_status        = rsp_status_reg;
    assign rsp_block_address = rsp_baddr_reg;
    assign rsp_allocated     = rsp_alloc_reg;
    assign rsp_free          = rsp_free_reg;

endmodule

FILE: design/buddy_page_allocator.sv
// Top level of the buddy page allocator: controller, datapath and channels.
// One item at a time, from acceptance to the next ready. Allocate splits once per order it
// goes down, free merges once per order it goes up (at most MAX_ORDER merges), and init
// clears all NUM_PAGES entries, then frees each aligned block, merging where it can.
// A result not yet taken holds the next item at its result step; the memories are dual-port.
// After reset a clearing pass over all NUM_PAGES entries runs with req.ready low.
module buddy_page_allocator #(
    parameter int NUM_PAGES = 4096,
    parameter int MAX_ORDER = 12
) (
    input  logic                             clk,
    input  logic                             rst_n,
    bpa_req_if.sink                          req,
    bpa_rsp_if.source                        rsp,
    input  logic                             cfg_we,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bpa_pkg::PFN_W-1:0]        cfg_data
);

    bpa_pkg::bpa_cmd_t  cmd;
    bpa_pkg::bpa_stat_t stat;

    bpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bpa_datapath #(
        .NUM_PAGES (NUM_PAGES),
        .MAX_ORDER (MAX_ORDER)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_op             (req.op),
        .in_size           (req.size_bytes),
        .in_addr           (req.address),
        .rsp_ready         (rsp.ready),
        .cmd               (cmd),
        .stat              (stat),
        .rsp_valid         (rsp.valid),
        .rsp_status        (rsp.status),
        .rsp_block_address (rsp.block_address),
        .rsp_allocated     (rsp.allocated_pages),
        .rsp_free          (rsp.free_pages)
    );

endmodule

FILE: design/bpa_checker.sv
// Port-level checker of the buddy page allocator and its bind statement.
`include "buddy_page_allocator_assert.svh"

module bpa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [bpa_pkg::ST_W-1:0]       rsp_status,
    input logic [bpa_pkg::ADDR_W-1:0]     rsp_block_address
);

    // A stalled transfer keeps its valid and its address.
    `BPA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    `BPA_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready, $stable(rsp_block_address))

    // Failed items never carry an address, and addresses are page aligned.
    `BPA_ASSERT_NOW(a_fail_zero, clk, rst_n, rsp_valid && (rsp_status != bpa_pkg::ST_OK), rsp_block_address == '0)
    `BPA_ASSERT_NOW(a_page_align, clk, rst_n, rsp_valid, rsp_block_address[bpa_pkg::PAGE_SHIFT-1:0] == '0)

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_block_address (rsp.block_address)
);
